FILE: rtl/rrq_pkg.sv
// ----------------------------------------------------------------------------
// rrq_pkg
// Shared types, sizes and helpers for the report ring queue with statistics.
// ----------------------------------------------------------------------------
package rrq_pkg;

	localparam int QUEUE_SLOTS = 16;
	localparam int MAX_BYTES   = 8;
	localparam int IDX_W       = $clog2(QUEUE_SLOTS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int LEN_W       = $clog2(MAX_BYTES + 1);
	localparam int STAT_W      = 32;

	typedef enum logic [2:0] {
		CMD_SET_TIME = 3'd0,
		CMD_PUSH     = 3'd1,
		CMD_POP      = 3'd2,
		CMD_PEEK     = 3'd3,
		CMD_COUNT    = 3'd4
	} cmd_t;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [7:0]       kind;
		logic [LEN_W-1:0] len;
		logic [63:0]      payload;
		logic [63:0]      stamp;
	} entry_t;

	typedef struct packed {
		logic push;
		logic drop;
		logic usb;
		logic ble;
		logic fail;
	} stat_inc_t;

	typedef struct packed {
		logic [STAT_W-1:0] push;
		logic [STAT_W-1:0] drop;
		logic [STAT_W-1:0] usb;
		logic [STAT_W-1:0] ble;
		logic [STAT_W-1:0] fail;
	} stat_tot_t;

	function automatic idx_t next_slot(input idx_t i);
		idx_t n;
		if (i == idx_t'(QUEUE_SLOTS - 1)) begin
			n = '0;
		end else begin
			n = i + idx_t'(1);
		end
		return n;
	endfunction

	// keep bytes below the length, zero the rest
	function automatic logic [63:0] byte_mask(input logic [LEN_W-1:0] n);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (int'(n) > i) begin
				m[8*i +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

FILE: rtl/rrq_store.sv
// ----------------------------------------------------------------------------
// rrq_store
// Slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rrq_store
	import rrq_pkg::*;
(
	input  logic   clk,
	input  logic   wr_en,
	input  idx_t   wr_addr,
	input  entry_t wr_data,
	input  logic   rd_en,
	input  idx_t   rd_addr,
	output entry_t rd_data
);

	entry_t mem [QUEUE_SLOTS];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/rrq_stats.sv
// ----------------------------------------------------------------------------
// rrq_stats
// Five wrapping event counters for pushes, drops and send outcomes.
// ----------------------------------------------------------------------------
module rrq_stats
	import rrq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  stat_inc_t inc,
	output stat_tot_t totals
);

	stat_tot_t tot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q <= '0;
		end else begin
			if (inc.push) tot_q.push <= tot_q.push + STAT_W'(1);
			if (inc.drop) tot_q.drop <= tot_q.drop + STAT_W'(1);
			if (inc.usb)  tot_q.usb  <= tot_q.usb  + STAT_W'(1);
			if (inc.ble)  tot_q.ble  <= tot_q.ble  + STAT_W'(1);
			if (inc.fail) tot_q.fail <= tot_q.fail + STAT_W'(1);
		end
	end

	assign totals = tot_q;

endmodule

FILE: rtl/report_ring_queue_with_stats.sv
// ----------------------------------------------------------------------------
// report_ring_queue_with_stats
// Ring queue of input reports (one slot kept empty) with event counters.
// ----------------------------------------------------------------------------
// The accept edge of a command word updates pointers and counters, writes
// a pushed slot and starts the slot memory read for pop or peek; the next
// edge loads the result register from the registered read data. A new word
// is taken once no slot read is in flight and the result register is free
// or being taken in the same cycle. Depth and counters on the result port
// show the state after the command. Slots hold QUEUE_SLOTS-1 reports at most.
module report_ring_queue_with_stats
	import rrq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  command,
	input  logic [7:0]  report_kind,
	input  logic [7:0]  report_length,
	input  logic [63:0] report_payload,
	input  logic [63:0] stamp_value,
	input  logic        via_usb,
	input  logic        send_ok,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        success,
	output logic [7:0]  head_kind,
	output logic [3:0]  head_length,
	output logic [63:0] head_payload,
	output logic [63:0] head_stamp,
	output logic [3:0]  fill_depth,
	output logic [31:0] pushed_total,
	output logic [31:0] dropped_total,
	output logic [31:0] usb_sent_total,
	output logic [31:0] ble_sent_total,
	output logic [31:0] failed_total
);

	idx_t        wr_q, rd_q;
	logic [63:0] stamp_q;
	logic        busy_s1, ok_s1, kind_s1, full_s1;
	logic        rsp_valid_q, success_q;
	logic [7:0]  kind_q;
	logic [3:0]  length_q;
	logic [63:0] payload_q, stamp_out_q;

	logic        req_fire, is_full, is_empty;
	logic        do_push, do_pop, do_read, ok_now;
	cmd_t        cmd;
	logic [LEN_W-1:0] len_clip;
	entry_t      wr_entry, rd_entry;
	stat_inc_t   inc;
	stat_tot_t   totals;
	logic [CNT_W-1:0] depth;

	assign cmd       = cmd_t'(command);
	assign req_stall = busy_s1 | (rsp_valid_q & rsp_stall);
	assign req_fire  = req_valid & ~req_stall;
	assign is_full   = (next_slot(wr_q) == rd_q);
	assign is_empty  = (wr_q == rd_q);

	assign len_clip = (report_length > 8'(MAX_BYTES)) ? LEN_W'(MAX_BYTES)
	                                                  : LEN_W'(report_length);

	always_comb begin
		do_push = 1'b0;
		do_pop  = 1'b0;
		do_read = 1'b0;
		ok_now  = 1'b1;
		inc     = '0;
		if (req_fire) begin
			case (cmd)
				CMD_PUSH: begin
					do_push  = ~is_full;
					inc.push = ~is_full;
					inc.drop = is_full;
					ok_now   = ~is_full;
				end
				CMD_POP: begin
					do_pop  = ~is_empty;
					do_read = ~is_empty;
					ok_now  = ~is_empty;
				end
				CMD_PEEK: begin
					do_read = ~is_empty;
					ok_now  = ~is_empty;
				end
				CMD_COUNT: begin
					inc.fail = ~send_ok;
					inc.usb  = send_ok & via_usb;
					inc.ble  = send_ok & ~via_usb;
				end
				default: begin
				end
			endcase
		end
	end

	assign wr_entry.kind    = report_kind;
	assign wr_entry.len     = len_clip;
	assign wr_entry.payload = report_payload & byte_mask(len_clip);
	assign wr_entry.stamp   = stamp_q;

	rrq_store u_store (
		.clk     (clk),
		.wr_en   (do_push),
		.wr_addr (wr_q),
		.wr_data (wr_entry),
		.rd_en   (do_read),
		.rd_addr (rd_q),
		.rd_data (rd_entry)
	);

	rrq_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.inc    (inc),
		.totals (totals)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			stamp_q <= '0;
		end else begin
			if (do_push) wr_q <= next_slot(wr_q);
			if (do_pop)  rd_q <= next_slot(rd_q);
			if (req_fire && cmd == CMD_SET_TIME) stamp_q <= stamp_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			busy_s1 <= req_fire;
			if (busy_s1) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			ok_s1   <= ok_now;
			kind_s1 <= do_read;
			full_s1 <= do_pop;
		end
	end

	// result fields come from the slot read issued at accept
	always_ff @(posedge clk) begin
		if (busy_s1) begin
			success_q   <= ok_s1;
			kind_q      <= kind_s1 ? rd_entry.kind : '0;
			length_q    <= full_s1 ? 4'(rd_entry.len) : '0;
			payload_q   <= full_s1 ? rd_entry.payload : '0;
			stamp_out_q <= full_s1 ? rd_entry.stamp : '0;
		end
	end

	assign depth = (wr_q >= rd_q) ? (CNT_W'(wr_q) - CNT_W'(rd_q))
	                              : (CNT_W'(QUEUE_SLOTS) - CNT_W'(rd_q) + CNT_W'(wr_q));

	assign rsp_valid      = rsp_valid_q;
	assign success        = success_q;
	assign head_kind      = kind_q;
	assign head_length    = length_q;
	assign head_payload   = payload_q;
	assign head_stamp     = stamp_out_q;
	assign fill_depth     = 4'(depth);
	assign pushed_total   = totals.push;
	assign dropped_total  = totals.drop;
	assign usb_sent_total = totals.usb;
	assign ble_sent_total = totals.ble;
	assign failed_total   = totals.fail;

`ifndef SYNTHESIS
	a_no_accept_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> !req_fire)
		else $error("word accepted while slot read in flight");

	a_full_push_holds_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && cmd == CMD_PUSH && is_full) |=> $stable(wr_q))
		else $error("write pointer moved on dropped push");

	a_empty_pop_holds_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && cmd == CMD_POP && is_empty) |=> $stable(rd_q))
		else $error("read pointer moved on empty pop");

	a_rsp_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(req_fire, 2))
		else $error("result shown without an accepted word");
`endif

endmodule

FILE: tb/sv/report_ring_queue_with_stats_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// report_ring_queue_with_stats_check
// Watches both channels of the report ring queue, keeps its own model of the
// ring, the latched key time and the five counters, predicts one reply per
// accepted word and compares each reply, field by field, in order.
// ----------------------------------------------------------------------------
module report_ring_queue_with_stats_check
	import rrq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [2:0]  command,
	input  logic [7:0]  report_kind,
	input  logic [7:0]  report_length,
	input  logic [63:0] report_payload,
	input  logic [63:0] stamp_value,
	input  logic        via_usb,
	input  logic        send_ok,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic        success,
	input  logic [7:0]  head_kind,
	input  logic [3:0]  head_length,
	input  logic [63:0] head_payload,
	input  logic [63:0] head_stamp,
	input  logic [3:0]  fill_depth,
	input  logic [31:0] pushed_total,
	input  logic [31:0] dropped_total,
	input  logic [31:0] usb_sent_total,
	input  logic [31:0] ble_sent_total,
	input  logic [31:0] failed_total,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic        found;
		logic [7:0]  kind;
		logic [3:0]  len;
		logic [63:0] payload;
		logic [63:0] stamp;
		logic [3:0]  depth;
		logic [31:0] pushes;
		logic [31:0] drops;
		logic [31:0] usb_sends;
		logic [31:0] ble_sends;
		logic [31:0] fails;
	} reply_t;

	logic [7:0]  slot_kind    [QUEUE_SLOTS];
	logic [3:0]  slot_len     [QUEUE_SLOTS];
	logic [63:0] slot_payload [QUEUE_SLOTS];
	logic [63:0] slot_stamp   [QUEUE_SLOTS];
	int unsigned rd_ptr;
	int unsigned wr_ptr;
	logic [63:0] key_stamp;
	logic [31:0] push_tot;
	logic [31:0] drop_tot;
	logic [31:0] usb_tot;
	logic [31:0] ble_tot;
	logic [31:0] fail_tot;
	reply_t      expected_replies[$];

	// apply the word on the channel to the model and build its reply
	task automatic predict_reply(output reply_t r);
		int unsigned clipped;
		int unsigned nxt;
		logic [63:0] keep;
		r = '0;
		r.found = 1'b1;
		nxt = (wr_ptr + 1) % QUEUE_SLOTS;
		case (command)
			CMD_SET_TIME: begin
				key_stamp = stamp_value;
			end
			CMD_PUSH: begin
				clipped = (report_length > MAX_BYTES) ? MAX_BYTES : report_length;
				keep = (clipped >= 8) ? {64{1'b1}} : (64'd1 << (8 * clipped)) - 64'd1;
				if (nxt == rd_ptr) begin
					drop_tot++;
					r.found = 1'b0;
				end else begin
					slot_kind[wr_ptr]    = report_kind;
					slot_len[wr_ptr]     = 4'(clipped);
					slot_payload[wr_ptr] = report_payload & keep;
					slot_stamp[wr_ptr]   = key_stamp;
					wr_ptr = nxt;
					push_tot++;
				end
			end
			CMD_POP, CMD_PEEK: begin
				if (rd_ptr == wr_ptr) begin
					r.found = 1'b0;
				end else begin
					r.kind = slot_kind[rd_ptr];
					// peek leaves the head in place and reports its kind only
					if (command == CMD_POP) begin
						r.len     = slot_len[rd_ptr];
						r.payload = slot_payload[rd_ptr];
						r.stamp   = slot_stamp[rd_ptr];
						rd_ptr = (rd_ptr + 1) % QUEUE_SLOTS;
					end
				end
			end
			CMD_COUNT: begin
				if (!send_ok) begin
					fail_tot++;
				end else if (via_usb) begin
					usb_tot++;
				end else begin
					ble_tot++;
				end
			end
			default: begin
			end
		endcase
		r.depth     = 4'((wr_ptr + QUEUE_SLOTS - rd_ptr) % QUEUE_SLOTS);
		r.pushes    = push_tot;
		r.drops     = drop_tot;
		r.usb_sends = usb_tot;
		r.ble_sends = ble_tot;
		r.fails     = fail_tot;
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reply_t r;
		reply_t w;
		if (!arst_n) begin
			rd_ptr = 0;
			wr_ptr = 0;
			key_stamp = '0;
			push_tot = '0;
			drop_tot = '0;
			usb_tot = '0;
			ble_tot = '0;
			fail_tot = '0;
			expected_replies.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				predict_reply(r);
				expected_replies.push_back(r);
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_replies.size() == 0) begin
					mismatches++;
					$error("reply with no word outstanding");
				end else begin
					w = expected_replies.pop_front();
					compare_field("success", w.found, success);
					compare_field("head_kind", w.kind, head_kind);
					compare_field("head_length", w.len, head_length);
					compare_field("head_payload", w.payload, head_payload);
					compare_field("head_stamp", w.stamp, head_stamp);
					compare_field("fill_depth", w.depth, fill_depth);
					compare_field("pushed_total", w.pushes, pushed_total);
					compare_field("dropped_total", w.drops, dropped_total);
					compare_field("usb_sent_total", w.usb_sends, usb_sent_total);
					compare_field("ble_sent_total", w.ble_sends, ble_sent_total);
					compare_field("failed_total", w.fails, failed_total);
				end
			end
			outstanding <= expected_replies.size();
		end
	end

endmodule

FILE: tb/sv/report_ring_queue_with_stats_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// report_ring_queue_with_stats_test
// Drives command words into the report ring queue: a directed opening, a
// long receiver hold-off that backs the block up, then random bursts of
// pushes and pops with noise, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module report_ring_queue_with_stats_test;
	import rrq_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_WORDS = 900;
	localparam int HOLD_CYCLES  = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [2:0]  command = CMD_SET_TIME;
	logic [7:0]  report_kind = '0;
	logic [7:0]  report_length = '0;
	logic [63:0] report_payload = '0;
	logic [63:0] stamp_value = '0;
	logic        via_usb = 1'b0;
	logic        send_ok = 1'b0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic        success;
	logic [7:0]  head_kind;
	logic [3:0]  head_length;
	logic [63:0] head_payload;
	logic [63:0] head_stamp;
	logic [3:0]  fill_depth;
	logic [31:0] pushed_total;
	logic [31:0] dropped_total;
	logic [31:0] usb_sent_total;
	logic [31:0] ble_sent_total;
	logic [31:0] failed_total;

	int mismatches;
	int outstanding;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int words_sent = 0;
	int quiet_cycles = 0;
	bit hold_req = 1'b0;

	report_ring_queue_with_stats dut (.*);

	report_ring_queue_with_stats_check u_check (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// offer one word, idling first at the current rate, and wait for it to go in
	task automatic send_word(input logic [2:0] cmd, input logic [7:0] kind,
			input logic [7:0] len, input logic [63:0] pay, input logic [63:0] stamp,
			input logic usb, input logic ok);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid      <= 1'b1;
		command        <= cmd;
		report_kind    <= kind;
		report_length  <= len;
		report_payload <= pay;
		stamp_value    <= stamp;
		via_usb        <= usb;
		send_ok        <= ok;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		if (cmd <= CMD_COUNT) begin
			words_sent++;
		end
	endtask

	task automatic push_random();
		logic [7:0] len;
		// mostly legal lengths, sometimes anything up to 255
		len = ($urandom_range(99) < 80) ? 8'($urandom_range(MAX_BYTES)) : 8'($urandom);
		send_word(CMD_PUSH, 8'($urandom), len, rand64(), rand64(), 1'($urandom),
			1'($urandom));
	endtask

	task automatic take_head(input logic [2:0] cmd);
		send_word(cmd, 8'($urandom), 8'($urandom), rand64(), rand64(), 1'($urandom),
			1'($urandom));
	endtask

	task automatic send_noise();
		send_word(3'($urandom_range(7)), 8'($urandom), 8'($urandom), rand64(), rand64(),
			1'($urandom), 1'($urandom));
	endtask

	// receiver side: random stalls, or a long hold-off on request
	initial begin : recv_side
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int pick;
		int run;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// empty ring, field extremes, clipping, every command
		take_head(CMD_POP);
		take_head(CMD_PEEK);
		send_word(CMD_SET_TIME, 8'h00, 8'h00, '0, {64{1'b1}}, 1'b0, 1'b0);
		send_word(CMD_PUSH, 8'h00, 8'd0, {64{1'b1}}, '0, 1'b1, 1'b1);
		send_word(CMD_PUSH, 8'hFF, 8'd255, {64{1'b1}}, '0, 1'b0, 1'b0);
		send_word(CMD_PUSH, 8'h5A, 8'(MAX_BYTES), rand64(), rand64(), 1'b1, 1'b0);
		send_word(CMD_PUSH, 8'hA5, 8'(MAX_BYTES + 1), rand64(), rand64(), 1'b0, 1'b1);
		send_word(CMD_PUSH, 8'h3C, 8'd3, rand64(), rand64(), 1'b1, 1'b1);
		take_head(CMD_PEEK);
		repeat (5) take_head(CMD_POP);
		take_head(CMD_PEEK);
		send_word(CMD_COUNT, 8'hFF, 8'hFF, rand64(), rand64(), 1'b1, 1'b1);
		send_word(CMD_COUNT, 8'h00, 8'h00, rand64(), rand64(), 1'b0, 1'b1);
		send_word(CMD_COUNT, 8'h00, 8'h00, rand64(), rand64(), 1'b1, 1'b0);
		send_word(CMD_COUNT, 8'h00, 8'h00, rand64(), rand64(), 1'b0, 1'b0);
		for (int c = int'(CMD_COUNT) + 1; c < 8; c++) begin
			send_word(3'(c), 8'($urandom), 8'($urandom), rand64(), rand64(), 1'b1, 1'b1);
		end
		send_word(CMD_SET_TIME, 8'h00, 8'h00, '0, '0, 1'b0, 1'b0);
		push_random();
		take_head(CMD_POP);

		// receiver holds off while words keep coming, so the block backs up
		hold_req = 1'b1;
		repeat (30) push_random();

		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			case (words_sent * 4 / RANDOM_WORDS)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			pick = $urandom_range(99);
			run = $urandom_range(20, 1);
			if (pick < 40) begin
				if ($urandom_range(99) < 20) begin
					send_word(CMD_SET_TIME, 8'($urandom), 8'($urandom), rand64(), rand64(),
						1'($urandom), 1'($urandom));
				end
				repeat (run) push_random();
			end else if (pick < 75) begin
				repeat (run) take_head(($urandom_range(99) < 25) ? CMD_PEEK : CMD_POP);
			end else begin
				send_noise();
			end
		end
		req_valid <= 1'b0;
		recv_stall_pct = 0;

		// let the checker count the last word before waiting on it
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/rrq_pkg.sv
rtl/rrq_store.sv
rtl/rrq_stats.sv
rtl/report_ring_queue_with_stats.sv
tb/sv/report_ring_queue_with_stats_check.sv
tb/sv/report_ring_queue_with_stats_test.sv
